// File: src/spi_frame_crc_checker_core_macros.svh
// assertion macros for the frame checker
`ifndef SPI_FRAME_CRC_CHECKER_CORE_MACROS_SVH
`define SPI_FRAME_CRC_CHECKER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SFCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frame checker assertion failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SFCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frame checker assertion failed");

`endif

// File: src/sfcc_pkg.sv
// types, constants and crc function of the frame checker
package sfcc_pkg;

  localparam int RETAIN_BYTES = 32;
  localparam int IDX_W        = 7;

  localparam logic [15:0] CRC_POLY      = 16'hA001;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [7:0]  MODEL_RESET   = 8'd83;
  localparam logic [7:0]  ALL_ONES_BYTE = 8'hFF;

  localparam logic [IDX_W-1:0] HDR_LAST     = IDX_W'(6);
  localparam logic [IDX_W-1:0] MODEL_IDX    = IDX_W'(2);
  localparam logic [IDX_W-1:0] HDR_CRC_LO   = IDX_W'(7);
  localparam logic [IDX_W-1:0] HDR_CRC_HI   = IDX_W'(8);
  localparam logic [IDX_W-1:0] DATA_FIRST   = IDX_W'(9);
  localparam logic [IDX_W-1:0] DATA_LAST    = IDX_W'(32 + RETAIN_BYTES);
  localparam logic [IDX_W-1:0] DATA_CRC_LO  = IDX_W'(33 + RETAIN_BYTES);
  localparam logic [IDX_W-1:0] FRAME_LAST   = IDX_W'(34 + RETAIN_BYTES);
  localparam logic [IDX_W-1:0] SENSOR_FIRST = IDX_W'(15);
  localparam logic [IDX_W-1:0] SENSOR_LAST  = IDX_W'(30);

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_HDR_CRC   = 2'd1;
  localparam logic [1:0] STATUS_MODEL     = 2'd2;
  localparam logic [1:0] STATUS_DATA_CRC  = 2'd3;

  // apb register map
  localparam int         ADDR_W             = 3;
  localparam logic [0:0] REG_EXPECTED_MODEL = 1'b0;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } rx_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] byte_index;
    logic [7:0]       byte_value;
    logic             last;
    logic [1:0]       status;
    logic [3:0]       sensor_errors;
  } result_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [7:0]       value;
    logic             first;
    logic             hdr_crc;
    logic             model_chk;
    logic             hdr_lo;
    logic             hdr_hi;
    logic             data_crc;
    logic             data_lo;
    logic             sensor;
    logic             last;
  } cls_item_t;

  // reflected crc-16 update by one byte
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int n = 0; n < 8; n++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: src/spi_frame_crc_checker_core.sv
// top level of the received-frame crc checker
// Checks received I/O-board frames one byte per item and echoes every byte with
// its index. Bytes 0..6 are the header, protected by a reflected CRC-16 (poly
// 0xA001, start 0xFFFF) stored low byte first in bytes 7..8; byte 2 must equal
// the expected_model register (APB address 0, reset 83). Bytes 9..64 are
// covered by a data CRC in bytes 65..66. The item on byte 66 carries last=1,
// the status (0 ok, 1 header crc, 2 model, 3 data crc; header crc beats model,
// data crc counts only if neither failed) and four sensor-error flags (sensor
// k: bytes 15+4k..18+4k all 0xFF). frame_start restarts the frame at any byte;
// after byte 66 the next byte is byte 0. Throughput is one item per cycle while
// the result side does not stall, set by the combinational 8-bit crc update in
// the back end; each result passes the queue, then the output register.
// A two-entry queue separates the classifier from the checker, so input keeps
// flowing while a result waits on the output register.
module spi_frame_crc_checker_core
  import sfcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // byte input
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  rx_item_t          in_data_i,
  // result output
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output result_t           out_data_o,
  // apb register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [7:0] expected_model_q;
  logic       accept, q_full, q_valid, q_pop;
  cls_item_t  cls_item, q_item;

  // apb: always ready, register selected by word address
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EXPECTED_MODEL) ? {24'h0, expected_model_q} : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_model_q <= MODEL_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_EXPECTED_MODEL)) begin
      expected_model_q <= pwdata[7:0];
    end
  end

  // front end takes a byte whenever the queue has room
  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && !q_full;

  sfcc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .item_o    (cls_item)
  );

  sfcc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_item_i (cls_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_item_o  (q_item)
  );

  // back end pops when its output register is free or being drained
  logic back_ready;
  assign q_pop = q_valid && back_ready;

  sfcc_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (q_valid),
    .item_i           (q_item),
    .item_ready_o     (back_ready),
    .expected_model_i (expected_model_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_data_o       (out_data_o)
  );

endmodule

// File: src/sfcc_queue.sv
// small queue between classifier and checker
module sfcc_queue
  import sfcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cls_item_t push_item_i,
  output logic      full_o,
  input  logic      pop_i,
  output logic      valid_o,
  output cls_item_t pop_item_o
);

  cls_item_t         mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q;

  assign full_o     = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// File: src/sfcc_front.sv
// frame position tracking and byte classification
module sfcc_front
  import sfcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      accept_i,
  input  rx_item_t  in_data_i,
  output cls_item_t item_o
);

  logic [IDX_W-1:0] position_q, position_d;
  logic [IDX_W-1:0] idx;

  assign idx = in_data_i.frame_start ? '0 : position_q;

  always_comb begin
    item_o.idx       = idx;
    item_o.value     = in_data_i.rx_byte;
    item_o.first     = (idx == '0);
    item_o.hdr_crc   = (idx <= HDR_LAST);
    item_o.model_chk = (idx == MODEL_IDX);
    item_o.hdr_lo    = (idx == HDR_CRC_LO);
    item_o.hdr_hi    = (idx == HDR_CRC_HI);
    item_o.data_crc  = (idx >= DATA_FIRST) && (idx <= DATA_LAST);
    item_o.data_lo   = (idx == DATA_CRC_LO);
    item_o.sensor    = (idx >= SENSOR_FIRST) && (idx <= SENSOR_LAST);
    item_o.last      = (idx == FRAME_LAST);
  end

  assign position_d = (idx == FRAME_LAST) ? '0 : idx + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
    end else if (accept_i) begin
      position_q <= position_d;
    end
  end

endmodule

// File: src/sfcc_back.sv
// crc, model and sensor checks with output register
module sfcc_back
  import sfcc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      item_valid_i,
  input  cls_item_t item_i,
  output logic      item_ready_o,
  input  logic [7:0] expected_model_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output result_t   out_data_o
);

  logic [15:0] hdr_crc_q, hdr_crc_d, data_crc_q, data_crc_d;
  logic [7:0]  low_q, low_d;
  logic [1:0]  err_q, err_d, err_final;
  logic        grp_q, grp_d;
  logic [3:0]  flags_q, flags_d;
  logic        out_valid_q;
  result_t     out_q, out_d;

  logic [15:0] hdr_base, data_base;
  logic [7:0]  low_base;
  logic [1:0]  err_base;
  logic        grp_base, byte_ok, take;
  logic [3:0]  flags_base, rel;

  assign item_ready_o = !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;

  // a first byte sees cleared per-frame state
  always_comb begin
    hdr_base   = item_i.first ? CRC_INIT : hdr_crc_q;
    data_base  = item_i.first ? CRC_INIT : data_crc_q;
    low_base   = item_i.first ? 8'h00 : low_q;
    err_base   = item_i.first ? STATUS_OK : err_q;
    grp_base   = item_i.first ? 1'b1 : grp_q;
    flags_base = item_i.first ? 4'h0 : flags_q;
    rel        = 4'(item_i.idx - SENSOR_FIRST);
    byte_ok    = (item_i.value == ALL_ONES_BYTE);

    hdr_crc_d  = item_i.hdr_crc ? crc_byte(hdr_base, item_i.value) : hdr_base;
    data_crc_d = item_i.data_crc ? crc_byte(data_base, item_i.value) : data_base;
    low_d      = (item_i.hdr_lo || item_i.data_lo) ? item_i.value : low_base;

    err_d = err_base;
    if (item_i.model_chk && (item_i.value != expected_model_i)) begin
      err_d = STATUS_MODEL;
    end
    if (item_i.hdr_hi && ({item_i.value, low_base} != hdr_base)) begin
      err_d = STATUS_HDR_CRC;
    end

    grp_d   = grp_base;
    flags_d = flags_base;
    if (item_i.sensor) begin
      grp_d = (rel[1:0] == 2'd0) ? byte_ok : (grp_base && byte_ok);
      if ((rel[1:0] == 2'd3) && grp_d) begin
        flags_d = flags_base | (4'b0001 << rel[3:2]);
      end
    end

    err_final = err_d;
    if (item_i.last && (err_d == STATUS_OK) && ({item_i.value, low_base} != data_base)) begin
      err_final = STATUS_DATA_CRC;
    end

    out_d.byte_index    = item_i.idx;
    out_d.byte_value    = item_i.value;
    out_d.last          = item_i.last;
    out_d.status        = item_i.last ? err_final : STATUS_OK;
    out_d.sensor_errors = item_i.last ? flags_d : 4'h0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_crc_q   <= CRC_INIT;
      data_crc_q  <= CRC_INIT;
      low_q       <= 8'h00;
      err_q       <= STATUS_OK;
      grp_q       <= 1'b1;
      flags_q     <= 4'h0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        hdr_crc_q  <= hdr_crc_d;
        data_crc_q <= data_crc_d;
        low_q      <= low_d;
        err_q      <= err_d;
        grp_q      <= grp_d;
        flags_q    <= flags_d;
      end
      if (item_ready_o) begin
        out_valid_q <= item_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: src/sfcc_checker.sv
// port-level assertions for the frame checker, bound to the top level
`include "spi_frame_crc_checker_core_macros.svh"

module sfcc_checker
  import sfcc_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    out_valid_o,
  input logic    out_ready_i,
  input result_t out_data_o,
  input logic    pready
);

  // a stalled result holds
  `SFCC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o))

  // last marks exactly the final frame position
  `SFCC_ASSERT_NOW(a_last_idx, out_valid_o, out_data_o.last == (out_data_o.byte_index == FRAME_LAST))

  // status and flags stay quiet before the final byte
  `SFCC_ASSERT_NOW(a_quiet_mid, out_valid_o && !out_data_o.last, (out_data_o.status == STATUS_OK) && (out_data_o.sensor_errors == 4'h0))

  // after a delivered final byte the next result is idle, at index zero, or not final
  `SFCC_ASSERT_NEXT(a_after_last, out_valid_o && out_ready_i && out_data_o.last, !out_valid_o || (out_data_o.byte_index == '0) || !out_data_o.last)

  // the register port never waits
  `SFCC_ASSERT_NOW(a_pready, 1'b1, pready)

endmodule

bind spi_frame_crc_checker_core sfcc_checker u_sfcc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

// File: dv/spi_frame_crc_checker_watch.sv
// scoreboard that predicts each echoed byte of the frame checker and compares it
`timescale 1ns / 1ps
module spi_frame_crc_checker_watch
  import sfcc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  rx_item_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  result_t           out_data_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic              pready_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [31:0]       pwdata_i,
  output int                err_count_o,
  output int                pending_o
);

  localparam logic [ADDR_W-1:0] MODEL_ADDR = ADDR_W'(4 * REG_EXPECTED_MODEL);

  // predicted block state
  logic [7:0]       model_q;
  logic [IDX_W-1:0] pos_q;
  logic [15:0]      hdr_crc_q;
  logic [15:0]      data_crc_q;
  logic [7:0]       crc_lo_q;
  logic [1:0]       status_q;
  logic             run_ones_q;
  logic [3:0]       flags_q;

  // echoes still owed by the block, oldest first
  result_t echo_due[$];

  // bit-serial form of the reflected crc, data bit fed in at the feedback tap
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic restart_frame();
    pos_q      = '0;
    hdr_crc_q  = CRC_INIT;
    data_crc_q = CRC_INIT;
    crc_lo_q   = '0;
    status_q   = STATUS_OK;
    run_ones_q = 1'b1;
    flags_q    = '0;
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t frame watch: mismatch, %s", $time, msg);
    err_count_o++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // one received byte through the frame state, returning the echo it causes
  task automatic advance_frame(input rx_item_t item, output result_t echo);
    logic [7:0]       b;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rel;
    logic             is_last;
    b = item.rx_byte;
    if (item.frame_start) restart_frame();
    idx = pos_q;

    if (idx <= HDR_LAST) hdr_crc_q = crc16_fold(hdr_crc_q, b);
    if (idx == MODEL_IDX && b != model_q) status_q = STATUS_MODEL;
    if (idx == HDR_CRC_LO) crc_lo_q = b;
    if (idx == HDR_CRC_HI && {b, crc_lo_q} != hdr_crc_q) status_q = STATUS_HDR_CRC;

    if (idx >= DATA_FIRST && idx <= DATA_LAST) data_crc_q = crc16_fold(data_crc_q, b);

    // four-byte sensor groups, flagged when every byte reads all ones
    if (idx >= SENSOR_FIRST && idx <= SENSOR_LAST) begin
      rel = idx - SENSOR_FIRST;
      if (rel[1:0] == 2'd0) run_ones_q = (b == ALL_ONES_BYTE);
      else run_ones_q = run_ones_q && (b == ALL_ONES_BYTE);
      if (rel[1:0] == 2'd3 && run_ones_q) flags_q[rel[3:2]] = 1'b1;
    end

    if (idx == DATA_CRC_LO) crc_lo_q = b;

    is_last = (idx == FRAME_LAST);
    if (is_last && status_q == STATUS_OK && {b, crc_lo_q} != data_crc_q)
      status_q = STATUS_DATA_CRC;

    echo.byte_index    = idx;
    echo.byte_value    = b;
    echo.last          = is_last;
    echo.status        = is_last ? status_q : STATUS_OK;
    echo.sensor_errors = is_last ? flags_q : 4'h0;

    if (is_last) restart_frame();
    else pos_q = idx + 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t echo;
    if (!rst_ni) begin
      model_q = MODEL_RESET;
      restart_frame();
      echo_due.delete();
      err_count_o = 0;
    end else begin
      // results first: an echo leaving now belongs to an earlier byte
      if (out_valid_i && out_ready_i) begin
        if (echo_due.size() == 0) begin
          report_mismatch($sformatf("unexpected item at index %0d", out_data_i.byte_index));
        end else begin
          want = echo_due.pop_front();
          check_field("byte_index", out_data_i.byte_index, want.byte_index);
          check_field("byte_value", out_data_i.byte_value, want.byte_value);
          check_field("last", out_data_i.last, want.last);
          check_field("status", out_data_i.status, want.status);
          check_field("sensor_errors", out_data_i.sensor_errors, want.sensor_errors);
        end
      end
      if (in_valid_i && in_ready_i) begin
        advance_frame(in_data_i, echo);
        echo_due.push_back(echo);
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == MODEL_ADDR)
        model_q = pwdata_i[7:0];
    end
    pending_o = echo_due.size();
  end

endmodule

// File: dv/tb_spi_frame_crc_checker_core.sv
// testbench top: drives frames and model register writes into the frame checker
`timescale 1ns / 1ps
module tb_spi_frame_crc_checker_core;
  import sfcc_pkg::*;

  localparam int ITEM_TARGET = 1900;
  localparam int PHASES      = 5;
  localparam int FRAME_LEN   = FRAME_LAST + 1;
  localparam int IDLE_LIMIT  = 1000;
  localparam logic [ADDR_W-1:0] MODEL_ADDR = ADDR_W'(4 * REG_EXPECTED_MODEL);

  // opening bytes: {frame_start, byte}; extremes, the reset model value and
  // restarts in the middle of the header
  localparam logic [8:0] WARMUP [16] = '{
    9'h100, 9'h0FF, 9'h053, 9'h0FF, 9'h100, 9'h1FF, 9'h0AA, 9'h055,
    9'h080, 9'h07F, 9'h001, 9'h0FE, 9'h1FF, 9'h0FF, 9'h000, 9'h1AA
  };

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  rx_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  result_t     out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int err_count;
  int pending;

  // stimulus bookkeeping
  int         sent      = 0;
  int         frame_pos = 0;     // where the block should stand in its frame
  bit         in_calm   = 1'b0;  // no gaps on the byte side for this frame
  logic [7:0] model_now = MODEL_RESET;

  spi_frame_crc_checker_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  spi_frame_crc_checker_watch watch (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .psel_i      (psel),
    .penable_i   (penable),
    .pwrite_i    (pwrite),
    .pready_i    (pready),
    .paddr_i     (paddr),
    .pwdata_i    (pwdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // one byte through the input handshake; valid stays up across back-to-back
  // items so the payload simply changes at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{rx_byte: b, frame_start: fs};
    do @(posedge clk); while (!in_ready);
    sent++;
    // frame_start restarts at byte 0, the final byte wraps back to 0
    frame_pos = fs ? 1 : frame_pos + 1;
    if (frame_pos == FRAME_LEN) frame_pos = 0;
  endtask

  // apb write: setup cycle, then access until pready
  task automatic write_model(input logic [7:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODEL_ADDR;
    pwdata  <= {24'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_now = v;
  endtask

  // stop feeding and let every owed echo come out, as counted by the scoreboard
  task automatic drain();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // build a full frame with valid or broken checks and send its first cut bytes
  task automatic send_frame(input bit model_ok, input bit hdr_ok, input bit data_ok,
                            input bit sensors_all, input int cut, input bit start);
    logic [7:0]  fr [FRAME_LEN];
    logic [15:0] crc;
    int          mode;
    int          odd;
    int          at;
    for (int i = 0; i < FRAME_LEN; i++) fr[i] = 8'($urandom);

    // a wrong model differs from the register in at least one bit
    if (model_ok) fr[MODEL_IDX] = model_now;
    else fr[MODEL_IDX] = model_now ^ 8'($urandom_range(1, 255));

    // sensor groups: all ones, all ones but one byte, or plain random
    for (int k = 0; k < 4; k++) begin
      mode = sensors_all ? 0 : $urandom_range(0, 2);
      odd  = $urandom_range(0, 3);
      for (int j = 0; j < 4; j++) begin
        at = SENSOR_FIRST + 4 * k + j;
        if (mode == 0 || (mode == 1 && j != odd)) fr[at] = ALL_ONES_BYTE;
        else if (mode == 1) fr[at] = 8'($urandom_range(0, 254));
      end
    end

    // header crc, low byte first, with a single flipped bit when broken
    crc = CRC_INIT;
    for (int i = 0; i <= HDR_LAST; i++) crc = crc_byte(crc, fr[i]);
    fr[HDR_CRC_LO] = crc[7:0];
    fr[HDR_CRC_HI] = crc[15:8];
    if (!hdr_ok) fr[HDR_CRC_LO + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));

    // data crc over the payload, stored in the last two bytes
    crc = CRC_INIT;
    for (int i = DATA_FIRST; i <= DATA_LAST; i++) crc = crc_byte(crc, fr[i]);
    fr[DATA_CRC_LO] = crc[7:0];
    fr[FRAME_LAST]  = crc[15:8];
    if (!data_ok) fr[DATA_CRC_LO + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));

    for (int i = 0; i < cut; i++) send_byte(fr[i], (i == 0) && start);
  endtask

  // main stimulus: warmup bytes, then phases of frames under different models
  initial begin
    int         frame_no;
    bit         m_ok;
    bit         h_ok;
    bit         d_ok;
    bit         s_all;
    bit         start;
    int         cut;
    logic [7:0] next_model;
    frame_no = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (WARMUP[i]) send_byte(WARMUP[i][7:0], WARMUP[i][8]);

    for (int p = 0; p < PHASES; p++) begin
      // phase 0 runs on the reset model, later ones on 0, 255, then random
      if (p > 0) begin
        drain();
        case (p)
          1:       next_model = 8'h00;
          2:       next_model = 8'hFF;
          default: next_model = 8'($urandom);
        endcase
        write_model(next_model);
      end

      while (sent < (p + 1) * ITEM_TARGET / PHASES) begin
        in_calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) begin
          // noise: short runs of raw bytes with stray frame starts
          repeat ($urandom_range(1, 20))
            send_byte(8'($urandom), 1'($urandom_range(0, 3) == 0));
        end else begin
          m_ok  = ($urandom_range(0, 4) != 0);
          h_ok  = ($urandom_range(0, 4) != 0);
          d_ok  = ($urandom_range(0, 3) != 0);
          s_all = ($urandom_range(0, 7) == 0);
          cut   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, FRAME_LEN - 1) : FRAME_LEN;
          // when the block sits at a boundary, a frame may begin without a start mark
          start = (frame_pos != 0) || ($urandom_range(0, 3) != 0);
          // the first frames walk every status outcome in turn
          if (frame_no < 7) begin
            m_ok  = 1'b1;
            h_ok  = 1'b1;
            d_ok  = 1'b1;
            s_all = 1'b0;
            cut   = FRAME_LEN;
            start = 1'b1;
            case (frame_no)
              1: m_ok = 1'b0;
              2: h_ok = 1'b0;
              3: begin
                m_ok = 1'b0;
                h_ok = 1'b0;
              end
              4: d_ok = 1'b0;
              5: begin
                m_ok = 1'b0;
                d_ok = 1'b0;
              end
              6: begin
                d_ok  = 1'b0;
                s_all = 1'b1;
              end
              default: ;
            endcase
          end
          send_frame(m_ok, h_ok, d_ok, s_all, cut, start);
          frame_no++;
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_spi_frame_crc_checker_core: done, clean");
    end else begin
      $display("tb_spi_frame_crc_checker_core: done, errors");
    end
    $finish;
  end

  // result side: random stall before each item, with calm stretches of no stall
  initial begin
    int stall;
    int served;
    bit out_calm;
    served   = 0;
    out_calm = 1'b0;
    @(posedge rst_n);
    forever begin
      if (served % 64 == 0) out_calm = ($urandom_range(0, 2) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      served++;
    end
  end

  // watchdog: too many cycles in a row without any handshake ends the run
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle = 0;
      else idle++;
    end
    $display("tb_spi_frame_crc_checker_core: done, errors");
    $finish;
  end

endmodule
